@@ src/hsih_pkg.sv @@
// ----------------------------------------------------------------------------
// hsih_pkg
// Shared types and constants of the hue by saturation integral histogram.
// ----------------------------------------------------------------------------
package hsih_pkg;

  localparam int DEF_MAX_ROWS     = 64;
  localparam int DEF_MAX_COLS     = 64;
  localparam int DEF_MAX_HUE_BINS = 4;
  localparam int DEF_MAX_SAT_BINS = 4;

  localparam int SUM_W   = 20;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;
  localparam int PATCH_W = 7;

  localparam logic [7:0] PIX_WEIGHT = 8'd255;

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_HBINS = 2'd2;
  localparam logic [1:0] REG_SBINS = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_QUERY,
    ST_BAD
  } state_t;

endpackage

@@ src/hue_sat_integral_histogram.sv @@
// ----------------------------------------------------------------------------
// hue_sat_integral_histogram
// Integral images per hue by saturation bin, kept in one synchronous memory.
// ----------------------------------------------------------------------------
// Load: each bin reads its left, upper and diagonal neighbors on the single
// read port, accumulates, then writes.
// Query: each bin takes four corner reads on the single read port, then an
// accumulate step and a hand-over step.
// Reset (rst, synchronous) clears control, position and registers to their
// highest counts; memory contents stay undefined until written.
module hue_sat_integral_histogram #(
  parameter int MAX_ROWS     = hsih_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS     = hsih_pkg::DEF_MAX_COLS,
  parameter int MAX_HUE_BINS = hsih_pkg::DEF_MAX_HUE_BINS,
  parameter int MAX_SAT_BINS = hsih_pkg::DEF_MAX_SAT_BINS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hsih_pkg::APB_AW-1:0]  paddr,
  input  logic [hsih_pkg::APB_DW-1:0]  pwdata,
  output logic [hsih_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic                         first_pixel,
  input  logic [7:0]                   hue,
  input  logic [7:0]                   sat,
  input  logic [5:0]                   patch_x,
  input  logic [5:0]                   patch_y,
  input  logic [5:0]                   patch_width,
  input  logic [5:0]                   patch_height,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   hue_bin,
  output logic [1:0]                   sat_bin,
  output logic [19:0]                  bin_sum,
  output logic                         bad_patch,
  output logic                         last
);
  import hsih_pkg::*;

  localparam int NBINS = MAX_HUE_BINS * MAX_SAT_BINS;
  localparam int HB_W  = (MAX_HUE_BINS > 1) ? $clog2(MAX_HUE_BINS) : 1;
  localparam int SB_W  = (MAX_SAT_BINS > 1) ? $clog2(MAX_SAT_BINS) : 1;
  localparam int HC_W  = $clog2(MAX_HUE_BINS + 1);
  localparam int SC_W  = $clog2(MAX_SAT_BINS + 1);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RC_W  = $clog2(MAX_ROWS + 1);
  localparam int CC_W  = $clog2(MAX_COLS + 1);
  localparam int DEPTH = NBINS * MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int HV_W  = 8 + HC_W;
  localparam int SV_W  = 8 + SC_W;
  localparam int PW    = (RW > CW) ? RW + 1 : CW + 1;
  localparam int QW    = (PW > PATCH_W) ? PW : PATCH_W;

  function automatic logic [AW-1:0] addr_of(input logic [HB_W-1:0] hb,
                                            input logic [SB_W-1:0] sb,
                                            input logic [RW-1:0]   r,
                                            input logic [CW-1:0]   c);
    addr_of = AW'(((int'(hb) * MAX_SAT_BINS + int'(sb)) * MAX_ROWS + int'(r))
                  * MAX_COLS + int'(c));
  endfunction

  // Configuration registers.
  logic [6:0] image_rows, image_cols;
  logic [2:0] hue_bin_count, sat_bin_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows    <= 7'd64;
      image_cols    <= 7'd64;
      hue_bin_count <= 3'd4;
      sat_bin_count <= 3'd4;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_ROWS:  image_rows    <= pwdata[6:0];
        REG_COLS:  image_cols    <= pwdata[6:0];
        REG_HBINS: hue_bin_count <= pwdata[2:0];
        REG_SBINS: sat_bin_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS:  prdata = APB_DW'(image_rows);
      REG_COLS:  prdata = APB_DW'(image_cols);
      REG_HBINS: prdata = APB_DW'(hue_bin_count);
      REG_SBINS: prdata = APB_DW'(sat_bin_count);
      default:   prdata = '0;
    endcase
  end

  // Counts as used, with zero taken as one and large values held at the maximum.
  logic [RC_W-1:0] rows;
  logic [CC_W-1:0] cols;
  logic [HC_W-1:0] nh;
  logic [SC_W-1:0] ns;

  always_comb begin
    if (image_rows == 7'd0)                rows = RC_W'(1);
    else if (int'(image_rows) > MAX_ROWS)  rows = RC_W'(MAX_ROWS);
    else                                   rows = RC_W'(image_rows);
    if (image_cols == 7'd0)                cols = CC_W'(1);
    else if (int'(image_cols) > MAX_COLS)  cols = CC_W'(MAX_COLS);
    else                                   cols = CC_W'(image_cols);
    if (hue_bin_count == 3'd0)                  nh = HC_W'(1);
    else if (int'(hue_bin_count) > MAX_HUE_BINS) nh = HC_W'(MAX_HUE_BINS);
    else                                        nh = HC_W'(hue_bin_count);
    if (sat_bin_count == 3'd0)                  ns = SC_W'(1);
    else if (int'(sat_bin_count) > MAX_SAT_BINS) ns = SC_W'(MAX_SAT_BINS);
    else                                        ns = SC_W'(sat_bin_count);
  end

  // Control state.
  state_t            state, state_next;
  logic [HB_W-1:0]   hb_cnt;
  logic [SB_W-1:0]   sb_cnt;
  logic [2:0]        q_phase;
  logic [RW-1:0]     row_pos;
  logic [CW-1:0]     col_pos;

  // Payload of the item at work.
  logic [RW-1:0]     ld_r;
  logic [CW-1:0]     ld_c;
  logic [HV_W-1:0]   hv;
  logic [SV_W-1:0]   sv;
  logic [QW-1:0]     q_y, q_x, q_yh, q_xw;

  logic accept, ld_write, q_issue, out_load, out_bad, out_free, last_bin, bad_now;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign last_bin = (int'(hb_cnt) == int'(nh) - 1) && (int'(sb_cnt) == int'(ns) - 1);
  assign bad_now  = (int'(patch_y) + int'(patch_height) >= int'(rows)) ||
                    (int'(patch_x) + int'(patch_width) >= int'(cols));

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ld_write   = 1'b0;
    q_issue    = 1'b0;
    out_load   = 1'b0;
    out_bad    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!op)         state_next = ST_LOAD;
          else if (bad_now) state_next = ST_BAD;
          else             state_next = ST_QUERY;
        end
      end
      ST_LOAD: begin
        q_issue = (q_phase < 3'd4);
        if (q_phase == 3'd5) begin
          ld_write = 1'b1;
          if (last_bin) state_next = ST_IDLE;
        end
      end
      ST_QUERY: begin
        q_issue = (q_phase < 3'd4);
        if (q_phase == 3'd5 && out_free) begin
          out_load = 1'b1;
          if (last_bin) state_next = ST_IDLE;
        end
      end
      ST_BAD: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_bad    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Raster position of the pixel being accepted and of the next one.
  logic            restart;
  logic [RW-1:0]   r0;
  logic [CW-1:0]   c0;
  logic [CW:0]     c_inc;
  logic [RW:0]     r_inc;

  always_comb begin
    restart = first_pixel || (row_pos >= rows) || (col_pos >= cols);
    r0      = restart ? '0 : row_pos;
    c0      = restart ? '0 : col_pos;
    c_inc   = {1'b0, c0} + 1'b1;
    r_inc   = {1'b0, r0} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos  <= '0;
      col_pos  <= '0;
      hb_cnt   <= '0;
      sb_cnt   <= '0;
      q_phase  <= '0;
    end else begin
      if (accept) begin
        hb_cnt  <= '0;
        sb_cnt  <= '0;
        q_phase <= '0;
        if (!op) begin
          if (c_inc >= cols) begin
            col_pos <= '0;
            row_pos <= (r_inc >= rows) ? '0 : RW'(r_inc);
          end else begin
            col_pos <= CW'(c_inc);
            row_pos <= r0;
          end
        end
      end else if (ld_write || out_load) begin
        q_phase <= '0;
        if (int'(sb_cnt) == int'(ns) - 1) begin
          sb_cnt <= '0;
          hb_cnt <= hb_cnt + 1'b1;
        end else begin
          sb_cnt <= sb_cnt + 1'b1;
        end
      end else if ((state == ST_QUERY || state == ST_LOAD) && q_phase != 3'd5) begin
        q_phase <= q_phase + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_r <= r0;
      ld_c <= c0;
      hv   <= HV_W'(hue) * HV_W'(nh);
      sv   <= SV_W'(sat) * SV_W'(ns);
      if (op) begin
        q_y  <= QW'(patch_y);
        q_x  <= QW'(patch_x);
        q_yh <= QW'(patch_y) + QW'(patch_height);
        q_xw <= QW'(patch_x) + QW'(patch_width);
      end else begin
        // A load reads its neighbors as the corners of a one-pixel patch.
        q_y  <= QW'(r0);
        q_x  <= QW'(c0);
        q_yh <= QW'(r0) + QW'(1);
        q_xw <= QW'(c0) + QW'(1);
      end
    end
  end

  // A value v lies in bin b of n when b*255 < v*n <= (b+1)*255.
  logic [HV_W-1:0] h_lo;
  logic [SV_W-1:0] s_lo;
  logic            bin_hit;

  always_comb begin
    h_lo    = HV_W'(hb_cnt) * HV_W'(PIX_WEIGHT);
    s_lo    = SV_W'(sb_cnt) * SV_W'(PIX_WEIGHT);
    bin_hit = (hv > h_lo) && (hv <= h_lo + HV_W'(PIX_WEIGHT)) &&
              (sv > s_lo) && (sv <= s_lo + SV_W'(PIX_WEIGHT));
  end

  // Corner selection: bottom-right, bottom-left, top-right, top-left. A corner
  // on row or column zero reads as zero. For a load the first corner is the
  // entry about to be written, so it reads as zero too.
  logic [QW-1:0] cy, cx;
  logic          c_zero;

  always_comb begin
    case (q_phase[1:0])
      2'd0:    begin cy = q_yh; cx = q_xw; end
      2'd1:    begin cy = q_yh; cx = q_x;  end
      2'd2:    begin cy = q_y;  cx = q_xw; end
      default: begin cy = q_y;  cx = q_x;  end
    endcase
    c_zero = (cy == '0) || (cx == '0) || (state == ST_LOAD && q_phase[1:0] == 2'd0);
  end

  // Integral store.
  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rdata, wdata;
  logic [AW-1:0]    raddr, waddr;

  assign raddr = addr_of(hb_cnt, sb_cnt, RW'(cy - 1'b1), CW'(cx - 1'b1));
  assign waddr = addr_of(hb_cnt, sb_cnt, ld_r, ld_c);

  always_ff @(posedge clk) begin
    if (ld_write) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Corner accumulation.
  logic             rd_act, rd_zero;
  logic [1:0]       rd_phase;
  logic [SUM_W-1:0] acc, corner_val;

  assign corner_val = rd_zero ? '0 : rdata;

  always_ff @(posedge clk) begin
    if (rst) rd_act <= 1'b0;
    else     rd_act <= q_issue;
    rd_phase <= q_phase[1:0];
    rd_zero  <= c_zero;
    if (rd_act) begin
      case (rd_phase)
        2'd0:    acc <= corner_val;
        2'd1:    acc <= acc - corner_val;
        2'd2:    acc <= acc - corner_val;
        default: acc <= acc + corner_val;
      endcase
    end
  end

  // For a load the accumulator ends as diagonal - left - above, so the new
  // entry is the pixel's weight minus it.
  assign wdata = (bin_hit ? SUM_W'(PIX_WEIGHT) : '0) - acc;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (out_load)  out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (out_load) begin
      hue_bin   <= out_bad ? 2'd0 : 2'(hb_cnt);
      sat_bin   <= out_bad ? 2'd0 : 2'(sb_cnt);
      bin_sum   <= out_bad ? '0 : acc;
      bad_patch <= out_bad;
      last      <= out_bad || last_bin;
    end
  end

endmodule

@@ src/hsih_checker.sv @@
// ----------------------------------------------------------------------------
// hsih_checker
// Port-level checks of the hue by saturation integral histogram.
// ----------------------------------------------------------------------------
module hsih_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         pready,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   hue_bin,
  input logic [1:0]                   sat_bin,
  input logic [19:0]                  bin_sum,
  input logic                         bad_patch,
  input logic                         last
);

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bin_sum) && $stable(last))
    else $error("stalled word changed");

  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_patch |-> last && bin_sum == 20'd0 && hue_bin == 2'd0 &&
    sat_bin == 2'd0)
    else $error("bad patch word malformed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("word valid after reset");

endmodule

bind hue_sat_integral_histogram hsih_checker u_hsih_checker (.*);

@@ bench/hue_sat_integral_histogram_tb.sv @@
// ----------------------------------------------------------------------------
// hue_sat_integral_histogram_tb
// Loads images of various sizes and bin counts, then checks every patch
// histogram word against a predictor that keeps its own integral images.
// ----------------------------------------------------------------------------
module hue_sat_integral_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsih_pkg::*;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct {
    logic       op;
    logic       fp;
    logic [7:0] hv;
    logic [7:0] sv;
    logic [5:0] px;
    logic [5:0] py;
    logic [5:0] pw;
    logic [5:0] ph;
  } pix_word_t;

  typedef struct {
    logic [1:0]  hb;
    logic [1:0]  sb;
    logic [19:0] sum;
    logic        bad;
    logic        lst;
  } bin_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall;
  logic op = 1'b0, first_pixel = 1'b0;
  logic [7:0] hue = '0, sat = '0;
  logic [5:0] patch_x = '0, patch_y = '0, patch_width = '0, patch_height = '0;
  logic out_valid, out_stall = 1'b0;
  logic [1:0] hue_bin, sat_bin;
  logic [19:0] bin_sum;
  logic bad_patch, last;

  hue_sat_integral_histogram DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pix_word_t pending_words[$];
  bin_word_t expected_bins[$];
  pix_word_t cur_word;
  logic      failed = 1'b0;
  logic      quiet = 1'b0;

  // Predictor state: integral images and raster position.
  logic [19:0] integral_img [4][4][64][64];
  int unsigned cur_row = 0, cur_col = 0;
  logic [6:0]  cfg_rows = 7'd64, cfg_cols = 7'd64;
  logic [2:0]  cfg_hbins = 3'd4, cfg_sbins = 3'd4;

  function automatic int unsigned clamp_count(int unsigned v, int unsigned mx);
    if (v == 0) return 1;
    return (v > mx) ? mx : v;
  endfunction

  function automatic bit bin_hit(int unsigned v, int unsigned b, int unsigned n);
    return v > (b * 255) / n && v <= ((b + 1) * 255) / n;
  endfunction

  function automatic logic [19:0] corner_sum(int hb, int sb, int unsigned y,
                                             int unsigned x);
    if (y == 0 || x == 0) return '0;
    return integral_img[hb][sb][y-1][x-1];
  endfunction

  task automatic predict_histogram(pix_word_t w);
    int unsigned rows, cols, nh, ns, r, c, y, x, ww, hh;
    logic [19:0] v;
    bin_word_t e;
    rows = clamp_count(cfg_rows, 64);
    cols = clamp_count(cfg_cols, 64);
    nh = clamp_count(cfg_hbins, 4);
    ns = clamp_count(cfg_sbins, 4);
    if (w.op == OP_LOAD) begin
      if (w.fp || cur_row >= rows || cur_col >= cols) begin
        cur_row = 0;
        cur_col = 0;
      end
      r = cur_row;
      c = cur_col;
      for (int hb = 0; hb < nh; hb++)
        for (int sb = 0; sb < ns; sb++) begin
          v = (bin_hit(w.hv, hb, nh) && bin_hit(w.sv, sb, ns)) ? 20'd255 : 20'd0;
          if (r > 0) v += integral_img[hb][sb][r-1][c];
          if (c > 0) v += integral_img[hb][sb][r][c-1];
          if (r > 0 && c > 0) v -= integral_img[hb][sb][r-1][c-1];
          integral_img[hb][sb][r][c] = v;
        end
      cur_col = c + 1;
      if (cur_col >= cols) begin
        cur_col = 0;
        cur_row = (r + 1 >= rows) ? 0 : r + 1;
      end
    end else begin
      x = w.px; y = w.py; ww = w.pw; hh = w.ph;
      if (y + hh >= rows || x + ww >= cols) begin
        e = '{2'd0, 2'd0, 20'd0, 1'b1, 1'b1};
        expected_bins.push_back(e);
      end else begin
        for (int hb = 0; hb < nh; hb++)
          for (int sb = 0; sb < ns; sb++) begin
            e.hb = 2'(hb);
            e.sb = 2'(sb);
            e.sum = corner_sum(hb, sb, y + hh, x + ww) - corner_sum(hb, sb, y + hh, x)
                  - corner_sum(hb, sb, y, x + ww) + corner_sum(hb, sb, y, x);
            e.bad = 1'b0;
            e.lst = (hb + 1 == nh && sb + 1 == ns);
            expected_bins.push_back(e);
          end
      end
    end
  endtask

  // Pixel and query driver.
  always @(posedge clk) begin
    logic take;
    take = in_valid && !in_stall;
    if (!rst) begin
      if (take) predict_histogram(cur_word);
      if (!in_valid || take) begin
        if (pending_words.size() > 0 && (quiet || $urandom_range(0, 99) >= 29)) begin
          cur_word = pending_words.pop_front();
          op <= cur_word.op;
          first_pixel <= cur_word.fp;
          hue <= cur_word.hv;
          sat <= cur_word.sv;
          patch_x <= cur_word.px;
          patch_y <= cur_word.py;
          patch_width <= cur_word.pw;
          patch_height <= cur_word.ph;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    bin_word_t e;
    if (!rst) begin
      out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 29);
      if (out_valid && !out_stall) begin
        if (expected_bins.size() == 0) begin
          $error("unexpected word: hue_bin %0d sat_bin %0d bin_sum %0d",
                 hue_bin, sat_bin, bin_sum);
          failed = 1'b1;
        end else begin
          e = expected_bins.pop_front();
          if (hue_bin !== e.hb) begin
            $error("hue_bin: expected %0d, got %0d", e.hb, hue_bin); failed = 1'b1;
          end
          if (sat_bin !== e.sb) begin
            $error("sat_bin: expected %0d, got %0d", e.sb, sat_bin); failed = 1'b1;
          end
          if (bin_sum !== e.sum) begin
            $error("bin_sum: expected %0d, got %0d", e.sum, bin_sum); failed = 1'b1;
          end
          if (bad_patch !== e.bad) begin
            $error("bad_patch: expected %0d, got %0d", e.bad, bad_patch); failed = 1'b1;
          end
          if (last !== e.lst) begin
            $error("last: expected %0d, got %0d", e.lst, last); failed = 1'b1;
          end
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ROWS:  cfg_rows = val[6:0];
      REG_COLS:  cfg_cols = val[6:0];
      REG_HBINS: cfg_hbins = val[2:0];
      default:   cfg_sbins = val[2:0];
    endcase
  endtask

  // Waits until every word has gone in, the block is idle and every result
  // has come out. Sampling on the falling edge sees the driver's updates.
  task automatic drain(int settle);
    @(negedge clk);
    while (pending_words.size() > 0 || in_valid || in_stall || expected_bins.size() > 0)
      @(negedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic push_load(logic fp, logic [7:0] hv, logic [7:0] sv);
    pix_word_t w;
    w = '{OP_LOAD, fp, hv, sv, 6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom)};
    pending_words.push_back(w);
  endtask

  task automatic push_query(logic [5:0] px, logic [5:0] py, logic [5:0] pw,
                            logic [5:0] ph);
    pix_word_t w;
    w = '{OP_QUERY, 1'($urandom), 8'($urandom), 8'($urandom), px, py, pw, ph};
    pending_words.push_back(w);
  endtask

  task automatic set_config(int r, int c, int nh, int ns);
    reg_write(REG_ROWS, r);
    reg_write(REG_COLS, c);
    reg_write(REG_HBINS, nh);
    reg_write(REG_SBINS, ns);
  endtask

  task automatic random_query();
    int unsigned rows, cols, x, y;
    rows = clamp_count(cfg_rows, 64);
    cols = clamp_count(cfg_cols, 64);
    if ($urandom_range(0, 99) < 20) begin
      push_query(6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
    end else begin
      y = $urandom_range(0, rows - 1);
      x = $urandom_range(0, cols - 1);
      push_query(6'(x), 6'(y), 6'($urandom_range(0, cols - 1 - x)),
                 6'($urandom_range(0, rows - 1 - y)));
    end
  endtask

  // One whole image, then a mix of queries and stray loads that overwrite it.
  task automatic run_image(int r, int c, int nh, int ns, int n_mixed);
    int unsigned total;
    set_config(r, c, nh, ns);
    total = clamp_count(cfg_rows, 64) * clamp_count(cfg_cols, 64);
    for (int i = 0; i < total; i++)
      push_load(i == 0, 8'($urandom), 8'($urandom));
    for (int i = 0; i < n_mixed; i++) begin
      if (i == n_mixed / 2) drain(0);
      if ($urandom_range(0, 99) < 65) random_query();
      else push_load($urandom_range(0, 9) == 0, 8'($urandom), 8'($urandom));
    end
    drain(30);
  endtask

  initial begin
    logic [7:0] edge_vals[16] = '{8'd0, 8'd1, 8'd63, 8'd64, 8'd127, 8'd128, 8'd191,
                                  8'd192, 8'd254, 8'd255, 8'd85, 8'd170, 8'd31,
                                  8'd200, 8'd100, 8'd255};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: a 4x4 image across the bin edges, then corner-case patches.
    set_config(4, 4, 4, 4);
    for (int i = 0; i < 16; i++) push_load(i == 0, edge_vals[i], edge_vals[15 - i]);
    push_query(0, 0, 3, 3);
    push_query(1, 1, 2, 2);
    push_query(2, 1, 0, 0);
    push_query(3, 0, 0, 3);
    push_query(63, 63, 63, 63);
    push_query(0, 0, 4, 0);
    push_query(0, 3, 0, 1);
    // Overrun: the next load wraps and overwrites the top-left pixel.
    push_load(1'b0, 8'd255, 8'd255);
    push_query(0, 0, 1, 1);
    // Leave the raster position mid-image for the shrink below.
    for (int i = 0; i < 9; i++) push_load(1'b0, 8'd128, 8'd64);
    drain(30);

    // Shrink to 2x2: the stale position falls outside and restarts at the top.
    set_config(2, 2, 2, 3);
    for (int i = 0; i < 4; i++) push_load(1'b0, 8'($urandom), 8'($urandom));
    push_query(0, 0, 1, 1);
    push_query(1, 0, 0, 1);
    drain(30);

    // Out-of-range register values clamp to the nearest legal count.
    run_image(0, 0, 0, 0, 12);
    run_image(127, 1, 7, 7, 12);
    run_image(1, 5, 1, 4, 12);
    quiet = 1'b1;
    run_image(4, 5, 4, 4, 20);
    quiet = 1'b0;
    for (int i = 0; i < 2; i++)
      run_image($urandom_range(1, 4), $urandom_range(1, 4),
                $urandom_range(1, 4), $urandom_range(1, 4), 12);

    drain(150);
    if (!failed) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
